>>> rtl/bpgc_pkg.sv
// Shared constants, types and stage map for the body pair gravity block.
// No dependencies; every other file of the block uses it.
package bpgc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W = 48;
   localparam int MASS_W = 32;
   localparam int RAD_W = 47;
   localparam int G_W = 32;
   localparam logic [G_W-1:0] GRAV_RESET = 32'd16777216;

   // multiplier: operands split into 32-bit limbs
   localparam int LIMB_W = 32;
   localparam int MUL_W = 128;
   localparam int MUL_LIMBS = MUL_W / LIMB_W;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ROW_W = MUL_W + LIMB_W * 2;
   localparam int MUL_LAT = 3;

   // square root of the squared distance
   localparam int SQ_W = 98;
   localparam int ROOT_W = 49;
   localparam int SQRT_STEPS = 49;

   // restoring divider, quotient capped at 2^DIV_STEPS
   localparam int DIV_W = 240;
   localparam int DIV_STEPS = 50;
   localparam int QUO_W = DIV_STEPS + 1;
   localparam int DIV_LAT = DIV_STEPS + 1;
   localparam int FORCE_SHIFT = 3 * FRAC_BITS;
   localparam int DEN_SHIFT = 40;

   // stage map of the main pipeline
   localparam int ST_A = 0;
   localparam int ST_AO = ST_A + MUL_LAT;
   localparam int ST_B = ST_AO + 1;
   localparam int ST_BO = ST_B + MUL_LAT;
   localparam int ST_CO = ST_BO + MUL_LAT;
   localparam int ST_SQ = ST_B + SQRT_STEPS;
   localparam int ST_D = ST_SQ + 1;
   localparam int ST_DIV = ST_D + MUL_LAT;
   localparam int ST_LAST = ST_DIV + DIV_LAT;

   typedef logic [MUL_W-1:0] mul_word_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [DIV_W-1:0] div_word_type;
   typedef logic [QUO_W-1:0] quo_type;
   typedef logic [SQ_W-1:0] sq_word_type;
   typedef logic [ROOT_W-1:0] root_type;

endpackage

>>> rtl/bpgc_if.sv
// Channel interfaces of the body pair gravity block: request, response, csr write.
// Depends on bpgc_pkg for field widths.
interface bpgc_req_if;
   logic valid;
   logic ready;
   logic signed [bpgc_pkg::DATA_W-1:0] first_pos_x, first_pos_y, first_vel_x, first_vel_y;
   logic [bpgc_pkg::MASS_W-1:0] first_mass;
   logic [bpgc_pkg::RAD_W-1:0] first_radius;
   logic signed [bpgc_pkg::DATA_W-1:0] second_pos_x, second_pos_y, second_vel_x, second_vel_y;
   logic [bpgc_pkg::MASS_W-1:0] second_mass;
   logic [bpgc_pkg::RAD_W-1:0] second_radius;
   modport source (output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
      first_mass, first_radius, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
      second_mass, second_radius, input ready);
   modport sink (input valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
      first_mass, first_radius, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
      second_mass, second_radius, output ready);
endinterface

interface bpgc_rsp_if;
   logic valid;
   logic ready;
   logic signed [bpgc_pkg::DATA_W-1:0] force_x, force_y;
   logic signed [bpgc_pkg::DATA_W-1:0] new_first_pos_x, new_first_pos_y;
   logic signed [bpgc_pkg::DATA_W-1:0] new_first_vel_x, new_first_vel_y;
   logic signed [bpgc_pkg::DATA_W-1:0] new_second_pos_x, new_second_pos_y;
   logic signed [bpgc_pkg::DATA_W-1:0] new_second_vel_x, new_second_vel_y;
   logic collided;
   modport source (output valid, force_x, force_y, new_first_pos_x, new_first_pos_y,
      new_first_vel_x, new_first_vel_y, new_second_pos_x, new_second_pos_y,
      new_second_vel_x, new_second_vel_y, collided, input ready);
   modport sink (input valid, force_x, force_y, new_first_pos_x, new_first_pos_y,
      new_first_vel_x, new_first_vel_y, new_second_pos_x, new_second_pos_y,
      new_second_vel_x, new_second_vel_y, collided, output ready);
endinterface

interface bpgc_csr_if;
   logic valid;
   logic ready;
   logic [bpgc_pkg::G_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/body_pair_gravity_collision.sv
// Pairwise gravity and overlap collision for two 2D bodies, fully pipelined.
// Depends on bpgc_pkg, bpgc_if, bpgc_mul, bpgc_isqrt and bpgc_div.
//
// Channels: req carries one body pair per beat, rsp returns one result beat
// per pair, csr writes the gravitational constant G (unsigned Q8.24).
// Throughput: one pair per cycle, with no gaps between beats, while rsp is not stalled.
// A pair passes through a multiplier group, a 49-stage square root, a second
// multiplier group and a 51-stage divider that works one quotient bit per stage,
// plus two hand-off registers and the output register; all ten quotients run
// side by side.
// The whole pipeline advances together: when rsp holds a beat that is not
// taken, every stage holds and req.ready is low, so nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and sets G to 1.0.
// csr is always ready; G is meant to change only while the block is empty.
module body_pair_gravity_collision (
   input logic        clock,
   input logic        reset,
   bpgc_req_if.sink   req,
   bpgc_rsp_if.source rsp,
   bpgc_csr_if.sink   csr
);

   typedef struct packed {
      logic signed [47:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
      logic [31:0]  m1, m2;
      logic [32:0]  msum;
      logic [47:0]  ssum, adx, ady, dvxm, dvym;
      logic         nx, ny, nvx, nvy;
      logic [97:0]  d2;
      logic [96:0]  dot;
      logic         sd;
      logic [63:0]  gm1;
      logic [79:0]  a4, a5, a6, a7;
      logic [176:0] e1, e2, e3, e4;
      logic [130:0] dmsum;
      logic [143:0] c1, c2;
      logic [48:0]  d;
      logic         hit;
      logic [47:0]  ov;
   } stage_type;

   typedef struct packed {
      logic [47:0] fx, fy, n1x, n1y, w1x, w1y, n2x, n2y, w2x, w2y;
      logic        collided;
   } result_type;

   localparam int NUM_A = 9;
   localparam int NUM_B = 6;
   localparam int NUM_C = 2;
   localparam int NUM_D = 6;
   localparam int NUM_DIV = 10;
   localparam logic signed [52:0] SAT_HI = $signed({6'b000000, {47{1'b1}}});
   localparam logic signed [52:0] SAT_LO = $signed({6'b111111, {47{1'b0}}});

   stage_type pipe_ff [bpgc_pkg::ST_LAST+1];
   stage_type pipe_in [bpgc_pkg::ST_LAST+1];
   logic valid_ff [bpgc_pkg::ST_LAST+1];
   result_type rsp_ff, rsp_in;
   logic rsp_valid_ff;
   logic [bpgc_pkg::G_W-1:0] grav_ff;
   logic advance;

   bpgc_pkg::mul_word_type ga_a [NUM_A], ga_b [NUM_A];
   bpgc_pkg::prod_type     ga_p [NUM_A];
   bpgc_pkg::mul_word_type gb_a [NUM_B], gb_b [NUM_B];
   bpgc_pkg::prod_type     gb_p [NUM_B];
   bpgc_pkg::mul_word_type gc_a [NUM_C], gc_b [NUM_C];
   bpgc_pkg::prod_type     gc_p [NUM_C];
   bpgc_pkg::mul_word_type gd_a [NUM_D], gd_b [NUM_D];
   bpgc_pkg::prod_type     gd_p [NUM_D];
   bpgc_pkg::div_word_type dv_num [NUM_DIV], dv_den [NUM_DIV];
   bpgc_pkg::quo_type      dv_q [NUM_DIV];
   bpgc_pkg::root_type     sq_root;

   function automatic logic signed [52:0] signed_q(input bpgc_pkg::quo_type q,
                                                  input logic neg);
      logic signed [52:0] v;
      v = $signed({2'b00, q});
      return neg ? -v : v;
   endfunction

   function automatic logic signed [52:0] ext53(input logic signed [47:0] x);
      return $signed({{5{x[47]}}, x});
   endfunction

   function automatic logic [47:0] sat48(input logic signed [52:0] v);
      logic signed [52:0] t;
      t = v;
      if (t > SAT_HI) t = SAT_HI;
      if (t < SAT_LO) t = SAT_LO;
      return t[47:0];
   endfunction

   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   // stage contents, with the few stages that pick up unit results
   always_comb begin
      logic signed [48:0] dx, dy, dvx, dvy;
      logic [48:0] ndx, ndy, ndvx, ndvy;
      logic [95:0] t1, t2;
      logic s1, s2;
      stage_type s;

      s = pipe_ff[0];
      s.p1x = req.first_pos_x;
      s.p1y = req.first_pos_y;
      s.v1x = req.first_vel_x;
      s.v1y = req.first_vel_y;
      s.p2x = req.second_pos_x;
      s.p2y = req.second_pos_y;
      s.v2x = req.second_vel_x;
      s.v2y = req.second_vel_y;
      s.m1 = req.first_mass;
      s.m2 = req.second_mass;
      s.msum = {1'b0, req.first_mass} + {1'b0, req.second_mass};
      s.ssum = {1'b0, req.first_radius} + {1'b0, req.second_radius};
      dx = {req.second_pos_x[47], req.second_pos_x} - {req.first_pos_x[47], req.first_pos_x};
      dy = {req.second_pos_y[47], req.second_pos_y} - {req.first_pos_y[47], req.first_pos_y};
      dvx = {req.second_vel_x[47], req.second_vel_x} - {req.first_vel_x[47], req.first_vel_x};
      dvy = {req.second_vel_y[47], req.second_vel_y} - {req.first_vel_y[47], req.first_vel_y};
      ndx = -dx;
      ndy = -dy;
      ndvx = -dvx;
      ndvy = -dvy;
      s.nx = dx[48];
      s.ny = dy[48];
      s.nvx = dvx[48];
      s.nvy = dvy[48];
      s.adx = dx[48] ? ndx[47:0] : dx[47:0];
      s.ady = dy[48] ? ndy[47:0] : dy[47:0];
      s.dvxm = dvx[48] ? ndvx[47:0] : dvx[47:0];
      s.dvym = dvy[48] ? ndvy[47:0] : dvy[47:0];
      pipe_in[0] = s;

      for (int k = 1; k <= bpgc_pkg::ST_LAST; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end

      // squared distance and signed dot product of relative velocity
      pipe_in[bpgc_pkg::ST_AO+1].d2 = ga_p[0][97:0] + ga_p[1][97:0];
      pipe_in[bpgc_pkg::ST_AO+1].gm1 = ga_p[2][63:0];
      pipe_in[bpgc_pkg::ST_AO+1].a4 = ga_p[3][79:0];
      pipe_in[bpgc_pkg::ST_AO+1].a5 = ga_p[4][79:0];
      pipe_in[bpgc_pkg::ST_AO+1].a6 = ga_p[5][79:0];
      pipe_in[bpgc_pkg::ST_AO+1].a7 = ga_p[6][79:0];
      t1 = ga_p[7][95:0];
      t2 = ga_p[8][95:0];
      s1 = pipe_ff[bpgc_pkg::ST_AO].nvx != pipe_ff[bpgc_pkg::ST_AO].nx;
      s2 = pipe_ff[bpgc_pkg::ST_AO].nvy != pipe_ff[bpgc_pkg::ST_AO].ny;
      if (s1 == s2) begin
         pipe_in[bpgc_pkg::ST_AO+1].dot = {1'b0, t1} + {1'b0, t2};
         pipe_in[bpgc_pkg::ST_AO+1].sd = s1;
      end else if (t1 >= t2) begin
         pipe_in[bpgc_pkg::ST_AO+1].dot = {1'b0, t1 - t2};
         pipe_in[bpgc_pkg::ST_AO+1].sd = s1;
      end else begin
         pipe_in[bpgc_pkg::ST_AO+1].dot = {1'b0, t2 - t1};
         pipe_in[bpgc_pkg::ST_AO+1].sd = s2;
      end

      pipe_in[bpgc_pkg::ST_BO+1].e1 = gb_p[1][176:0];
      pipe_in[bpgc_pkg::ST_BO+1].e2 = gb_p[2][176:0];
      pipe_in[bpgc_pkg::ST_BO+1].e3 = gb_p[3][176:0];
      pipe_in[bpgc_pkg::ST_BO+1].e4 = gb_p[4][176:0];
      pipe_in[bpgc_pkg::ST_BO+1].dmsum = gb_p[5][130:0];

      pipe_in[bpgc_pkg::ST_CO+1].c1 = gc_p[0][143:0];
      pipe_in[bpgc_pkg::ST_CO+1].c2 = gc_p[1][143:0];

      // overlap test needs the distance; coincident or massless pairs never hit
      pipe_in[bpgc_pkg::ST_SQ+1].d = sq_root;
      pipe_in[bpgc_pkg::ST_SQ+1].hit = (sq_root != '0)
         && (pipe_ff[bpgc_pkg::ST_SQ].msum != '0)
         && ({1'b0, pipe_ff[bpgc_pkg::ST_SQ].ssum} > sq_root);
      pipe_in[bpgc_pkg::ST_SQ+1].ov = pipe_ff[bpgc_pkg::ST_SQ].ssum - sq_root[47:0];
   end

   // multiplier operands, group by group
   always_comb begin
      ga_a[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].adx);
      ga_b[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].adx);
      ga_a[1] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].ady);
      ga_b[1] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].ady);
      ga_a[2] = bpgc_pkg::mul_word_type'(grav_ff);
      ga_b[2] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].m1);
      ga_a[3] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].adx);
      ga_b[3] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].m2);
      ga_a[4] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].ady);
      ga_b[4] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].m2);
      ga_a[5] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].adx);
      ga_b[5] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].m1);
      ga_a[6] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].ady);
      ga_b[6] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].m1);
      ga_a[7] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].dvxm);
      ga_b[7] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].adx);
      ga_a[8] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].dvym);
      ga_b[8] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_A].ady);

      gb_a[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].gm1);
      gb_b[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].m2);
      gb_a[1] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].a4);
      gb_b[1] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].dot);
      gb_a[2] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].a5);
      gb_b[2] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].dot);
      gb_a[3] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].a6);
      gb_b[3] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].dot);
      gb_a[4] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].a7);
      gb_b[4] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].dot);
      gb_a[5] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].d2);
      gb_b[5] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_B].msum);

      // G*m1*m2 feeds straight from the group B output register
      gc_a[0] = gb_p[0][bpgc_pkg::MUL_W-1:0];
      gc_b[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_BO].adx);
      gc_a[1] = gb_p[0][bpgc_pkg::MUL_W-1:0];
      gc_b[1] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_BO].ady);

      gd_a[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].d2);
      gd_b[0] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].d);
      gd_a[1] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].d);
      gd_b[1] = bpgc_pkg::mul_word_type'({pipe_ff[bpgc_pkg::ST_D].msum, 1'b0});
      gd_a[2] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].a4);
      gd_b[2] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].ov);
      gd_a[3] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].a5);
      gd_b[3] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].ov);
      gd_a[4] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].a6);
      gd_b[4] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].ov);
      gd_a[5] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].a7);
      gd_b[5] = bpgc_pkg::mul_word_type'(pipe_ff[bpgc_pkg::ST_D].ov);
   end

   // divider lanes: force x/y, push of each body, velocity change of each body
   always_comb begin
      dv_num[0] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].c1)
                << bpgc_pkg::FORCE_SHIFT;
      dv_num[1] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].c2)
                << bpgc_pkg::FORCE_SHIFT;
      dv_den[0] = bpgc_pkg::div_word_type'(gd_p[0]) << bpgc_pkg::DEN_SHIFT;
      dv_den[1] = bpgc_pkg::div_word_type'(gd_p[0]) << bpgc_pkg::DEN_SHIFT;
      for (int i = 2; i < 6; i++) begin
         dv_num[i] = bpgc_pkg::div_word_type'(gd_p[i]);
         dv_den[i] = bpgc_pkg::div_word_type'(gd_p[1]);
      end
      dv_num[6] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].e1) << 1;
      dv_num[7] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].e2) << 1;
      dv_num[8] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].e3) << 1;
      dv_num[9] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].e4) << 1;
      for (int i = 6; i < NUM_DIV; i++) begin
         dv_den[i] = bpgc_pkg::div_word_type'(pipe_ff[bpgc_pkg::ST_DIV].dmsum);
      end
   end

   always_comb begin
      stage_type s;
      logic fnz, vnx, vny;
      s = pipe_ff[bpgc_pkg::ST_LAST];
      fnz = s.d != '0;
      vnx = s.sd != s.nx;
      vny = s.sd != s.ny;
      rsp_in.fx = fnz ? sat48(signed_q(dv_q[0], s.nx)) : '0;
      rsp_in.fy = fnz ? sat48(signed_q(dv_q[1], s.ny)) : '0;
      rsp_in.collided = s.hit;
      if (s.hit) begin
         rsp_in.n1x = sat48(ext53(s.p1x) - signed_q(dv_q[2], s.nx));
         rsp_in.n1y = sat48(ext53(s.p1y) - signed_q(dv_q[3], s.ny));
         rsp_in.n2x = sat48(ext53(s.p2x) + signed_q(dv_q[4], s.nx));
         rsp_in.n2y = sat48(ext53(s.p2y) + signed_q(dv_q[5], s.ny));
         rsp_in.w1x = sat48(ext53(s.v1x) + signed_q(dv_q[6], vnx));
         rsp_in.w1y = sat48(ext53(s.v1y) + signed_q(dv_q[7], vny));
         rsp_in.w2x = sat48(ext53(s.v2x) - signed_q(dv_q[8], vnx));
         rsp_in.w2y = sat48(ext53(s.v2y) - signed_q(dv_q[9], vny));
      end else begin
         rsp_in.n1x = s.p1x;
         rsp_in.n1y = s.p1y;
         rsp_in.n2x = s.p2x;
         rsp_in.n2y = s.p2y;
         rsp_in.w1x = s.v1x;
         rsp_in.w1y = s.v1y;
         rsp_in.w2x = s.v2x;
         rsp_in.w2y = s.v2y;
      end
   end

   for (genvar i = 0; i < NUM_A; i++) begin : g_mul_a
      bpgc_mul u_mul (.clock(clock), .enable(advance), .a(ga_a[i]), .b(ga_b[i]),
                      .p(ga_p[i]));
   end
   for (genvar i = 0; i < NUM_B; i++) begin : g_mul_b
      bpgc_mul u_mul (.clock(clock), .enable(advance), .a(gb_a[i]), .b(gb_b[i]),
                      .p(gb_p[i]));
   end
   for (genvar i = 0; i < NUM_C; i++) begin : g_mul_c
      bpgc_mul u_mul (.clock(clock), .enable(advance), .a(gc_a[i]), .b(gc_b[i]),
                      .p(gc_p[i]));
   end
   for (genvar i = 0; i < NUM_D; i++) begin : g_mul_d
      bpgc_mul u_mul (.clock(clock), .enable(advance), .a(gd_a[i]), .b(gd_b[i]),
                      .p(gd_p[i]));
   end
   for (genvar i = 0; i < NUM_DIV; i++) begin : g_div
      bpgc_div u_div (.clock(clock), .enable(advance), .num(dv_num[i]), .den(dv_den[i]),
                      .quo(dv_q[i]));
   end

   bpgc_isqrt u_isqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (pipe_ff[bpgc_pkg::ST_B].d2),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= bpgc_pkg::ST_LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
         grav_ff <= bpgc_pkg::GRAV_RESET;
      end else begin
         if (csr.valid) begin
            grav_ff <= csr.data;
         end
         if (advance) begin
            valid_ff[0] <= req.valid;
            for (int k = 1; k <= bpgc_pkg::ST_LAST; k++) begin
               valid_ff[k] <= valid_ff[k-1];
            end
            rsp_valid_ff <= valid_ff[bpgc_pkg::ST_LAST];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.force_x = rsp_ff.fx;
   assign rsp.force_y = rsp_ff.fy;
   assign rsp.new_first_pos_x = rsp_ff.n1x;
   assign rsp.new_first_pos_y = rsp_ff.n1y;
   assign rsp.new_first_vel_x = rsp_ff.w1x;
   assign rsp.new_first_vel_y = rsp_ff.w1y;
   assign rsp.new_second_pos_x = rsp_ff.n2x;
   assign rsp.new_second_pos_y = rsp_ff.n2y;
   assign rsp.new_second_vel_x = rsp_ff.w2x;
   assign rsp.new_second_vel_y = rsp_ff.w2y;
   assign rsp.collided = rsp_ff.collided;

endmodule

>>> rtl/bpgc_mul.sv
// Pipelined 128x128 unsigned multiplier built from 32x32 limb products.
// Depends on bpgc_pkg.
module bpgc_mul (
   input  logic                   clock,
   input  logic                   enable,
   input  bpgc_pkg::mul_word_type a,
   input  bpgc_pkg::mul_word_type b,
   output bpgc_pkg::prod_type     p
);

   logic [2*bpgc_pkg::LIMB_W-1:0] pp_ff [bpgc_pkg::MUL_LIMBS][bpgc_pkg::MUL_LIMBS];
   logic [2*bpgc_pkg::LIMB_W-1:0] pp_in [bpgc_pkg::MUL_LIMBS][bpgc_pkg::MUL_LIMBS];
   logic [bpgc_pkg::ROW_W-1:0] row_ff [bpgc_pkg::MUL_LIMBS];
   logic [bpgc_pkg::ROW_W-1:0] row_in [bpgc_pkg::MUL_LIMBS];
   bpgc_pkg::prod_type p_ff, p_in;

   always_comb begin
      for (int i = 0; i < bpgc_pkg::MUL_LIMBS; i++) begin
         for (int j = 0; j < bpgc_pkg::MUL_LIMBS; j++) begin
            pp_in[i][j] = a[bpgc_pkg::LIMB_W*i +: bpgc_pkg::LIMB_W]
                        * b[bpgc_pkg::LIMB_W*j +: bpgc_pkg::LIMB_W];
         end
      end
   end

   // one row per limb of a
   always_comb begin
      for (int i = 0; i < bpgc_pkg::MUL_LIMBS; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < bpgc_pkg::MUL_LIMBS; j++) begin
            row_in[i] = row_in[i]
                      + (bpgc_pkg::ROW_W'(pp_ff[i][j]) << (bpgc_pkg::LIMB_W * j));
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < bpgc_pkg::MUL_LIMBS; i++) begin
         p_in = p_in + (bpgc_pkg::prod_type'(row_ff[i]) << (bpgc_pkg::LIMB_W * i));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pp_ff <= pp_in;
         row_ff <= row_in;
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

>>> rtl/bpgc_isqrt.sv
// Pipelined integer square root, one result bit per stage (floor of sqrt).
// Depends on bpgc_pkg.
module bpgc_isqrt (
   input  logic                  clock,
   input  logic                  enable,
   input  bpgc_pkg::sq_word_type radicand,
   output bpgc_pkg::root_type    root
);

   typedef struct packed {
      bpgc_pkg::sq_word_type op;
      bpgc_pkg::sq_word_type res;
   } sq_state_type;

   sq_state_type st_ff [bpgc_pkg::SQRT_STEPS];
   sq_state_type st_in [bpgc_pkg::SQRT_STEPS];

   function automatic sq_state_type sq_step(input sq_state_type s,
                                            input bpgc_pkg::sq_word_type one);
      sq_state_type r;
      bpgc_pkg::sq_word_type trial;
      trial = s.res + one;
      if (s.op >= trial) begin
         r.op = s.op - trial;
         r.res = (s.res >> 1) + one;
      end else begin
         r.op = s.op;
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   always_comb begin
      sq_state_type first;
      first.op = radicand;
      first.res = '0;
      st_in[0] = sq_step(first,
         bpgc_pkg::sq_word_type'(1) << (2 * (bpgc_pkg::SQRT_STEPS - 1)));
      for (int k = 1; k < bpgc_pkg::SQRT_STEPS; k++) begin
         st_in[k] = sq_step(st_ff[k-1],
            bpgc_pkg::sq_word_type'(1) << (2 * (bpgc_pkg::SQRT_STEPS - 1 - k)));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in;
      end
   end

   assign root = st_ff[bpgc_pkg::SQRT_STEPS-1].res[bpgc_pkg::ROOT_W-1:0];

endmodule

>>> rtl/bpgc_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient capped at 2^50.
// Depends on bpgc_pkg.
module bpgc_div (
   input  logic                   clock,
   input  logic                   enable,
   input  bpgc_pkg::div_word_type num,
   input  bpgc_pkg::div_word_type den,
   output bpgc_pkg::quo_type      quo
);

   typedef struct packed {
      bpgc_pkg::div_word_type rem;
      bpgc_pkg::div_word_type dsh;
      bpgc_pkg::quo_type      q;
      logic                   sat;
   } div_state_type;

   div_state_type st_ff [bpgc_pkg::DIV_LAT];
   div_state_type st_in [bpgc_pkg::DIV_LAT];

   always_comb begin
      // first stage only decides whether the quotient reaches the cap
      st_in[0].rem = num;
      st_in[0].dsh = den << (bpgc_pkg::DIV_STEPS - 1);
      st_in[0].q = '0;
      st_in[0].sat = (num >= (den << bpgc_pkg::DIV_STEPS));
      for (int j = 1; j < bpgc_pkg::DIV_LAT; j++) begin
         st_in[j] = st_ff[j-1];
         st_in[j].dsh = st_ff[j-1].dsh >> 1;
         if (st_ff[j-1].rem >= st_ff[j-1].dsh) begin
            st_in[j].rem = st_ff[j-1].rem - st_ff[j-1].dsh;
            st_in[j].q = st_ff[j-1].q
                       | (bpgc_pkg::quo_type'(1) << (bpgc_pkg::DIV_STEPS - j));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in;
      end
   end

   assign quo = st_ff[bpgc_pkg::DIV_LAT-1].sat
              ? (bpgc_pkg::quo_type'(1) << bpgc_pkg::DIV_STEPS)
              : st_ff[bpgc_pkg::DIV_LAT-1].q;

endmodule

>>> rtl/bpgc_checker.sv
// Port-level checks for the body pair gravity block, bound to the top level.
// Depends on bpgc_pkg and body_pair_gravity_collision.
module bpgc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bpgc_pkg::DATA_W-1:0] rsp_force_x
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat present right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp is stalled");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty output");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_force_x))
      else $error("rsp payload changed while stalled");

endmodule

bind body_pair_gravity_collision bpgc_checker u_bpgc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_force_x (rsp.force_x)
);

>>> bench/bpgc_checker.sv
// Passive checker for body_pair_gravity_collision: tracks G from csr beats,
// predicts each req beat's result and compares rsp beats in order.
// Depends on bpgc_pkg and the channel interfaces in bpgc_if.
module bpgc_scoreboard (
   input  logic  clock,
   input  logic  reset,
   bpgc_req_if   req,
   bpgc_rsp_if   rsp,
   bpgc_csr_if   csr,
   output int    mismatches,
   output int    pending
);

   typedef logic [319:0] wide_type;
   typedef logic signed [319:0] swide_type;

   typedef struct {
      logic [bpgc_pkg::DATA_W-1:0] fx, fy;
      logic [bpgc_pkg::DATA_W-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
      logic                        hit;
   } outcome_type;

   logic [bpgc_pkg::G_W-1:0] grav_q;
   outcome_type              outcome_q[$];

   function automatic logic [63:0] root_of(wide_type v);
      logic [63:0] r, c;
      r = '0;
      for (int b = 51; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (wide_type'(c) * wide_type'(c) <= v) r = c;
      end
      return r;
   endfunction

   // truncated quotient, capped at 2^50
   function automatic longint capped_quot(wide_type num, wide_type den);
      wide_type q;
      if (den == 0) return 0;
      q = num / den;
      if (q > (wide_type'(1) << 50)) q = wide_type'(1) << 50;
      return longint'(q[63:0]);
   endfunction

   function automatic logic [bpgc_pkg::DATA_W-1:0] clip48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) v = 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) v = -64'sh8000_0000_0000;
      return v[bpgc_pkg::DATA_W-1:0];
   endfunction

   function automatic outcome_type predict_pair(logic [bpgc_pkg::G_W-1:0] g);
      outcome_type o;
      longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, dx, dy, adx, ady;
      longint n1x, n1y, n2x, n2y, w1x, w1y, w2x, w2y, fx, fy, q;
      wide_type  m1, m2, msum, ssum, d2, d, gm, den, ov, dotm;
      swide_type dotv;
      logic      sd;
      p1x = longint'(req.first_pos_x);   p1y = longint'(req.first_pos_y);
      v1x = longint'(req.first_vel_x);   v1y = longint'(req.first_vel_y);
      p2x = longint'(req.second_pos_x);  p2y = longint'(req.second_pos_y);
      v2x = longint'(req.second_vel_x);  v2y = longint'(req.second_vel_y);
      m1 = wide_type'(req.first_mass);   m2 = wide_type'(req.second_mass);
      msum = m1 + m2;
      ssum = wide_type'(req.first_radius) + wide_type'(req.second_radius);
      dx = p2x - p1x;          dy = p2y - p1y;
      adx = dx < 0 ? -dx : dx; ady = dy < 0 ? -dy : dy;
      d2 = wide_type'(adx) * wide_type'(adx) + wide_type'(ady) * wide_type'(ady);
      d = wide_type'(root_of(d2));
      fx = 0; fy = 0;
      n1x = p1x; n1y = p1y; n2x = p2x; n2y = p2y;
      w1x = v1x; w1y = v1y; w2x = v2x; w2y = v2y;
      o.hit = 1'b0;
      if (d != 0) begin
         gm = wide_type'(g) * m1 * m2;
         den = (d2 * d) << bpgc_pkg::DEN_SHIFT;
         q = capped_quot((gm * wide_type'(adx)) << bpgc_pkg::FORCE_SHIFT, den);
         fx = dx < 0 ? -q : q;
         q = capped_quot((gm * wide_type'(ady)) << bpgc_pkg::FORCE_SHIFT, den);
         fy = dy < 0 ? -q : q;
      end
      // overlap only when distance and total mass are nonzero and radius sum strictly exceeds the distance
      if (d != 0 && msum != 0 && ssum > d) begin
         o.hit = 1'b1;
         den = d * 2 * msum;
         ov = ssum - d;
         q = capped_quot(wide_type'(adx) * m2 * ov, den);  n1x = p1x - (dx < 0 ? -q : q);
         q = capped_quot(wide_type'(ady) * m2 * ov, den);  n1y = p1y - (dy < 0 ? -q : q);
         q = capped_quot(wide_type'(adx) * m1 * ov, den);  n2x = p2x + (dx < 0 ? -q : q);
         q = capped_quot(wide_type'(ady) * m1 * ov, den);  n2y = p2y + (dy < 0 ? -q : q);
         dotv = swide_type'(v2x - v1x) * swide_type'(dx)
              + swide_type'(v2y - v1y) * swide_type'(dy);
         sd = dotv < 0;
         dotm = sd ? wide_type'(-dotv) : wide_type'(dotv);
         den = d2 * msum;
         q = capped_quot(2 * m2 * wide_type'(adx) * dotm, den);
         w1x = v1x + ((sd != (dx < 0)) ? -q : q);
         q = capped_quot(2 * m2 * wide_type'(ady) * dotm, den);
         w1y = v1y + ((sd != (dy < 0)) ? -q : q);
         q = capped_quot(2 * m1 * wide_type'(adx) * dotm, den);
         w2x = v2x - ((sd != (dx < 0)) ? -q : q);
         q = capped_quot(2 * m1 * wide_type'(ady) * dotm, den);
         w2y = v2y - ((sd != (dy < 0)) ? -q : q);
      end
      o.fx = clip48(fx);   o.fy = clip48(fy);
      o.p1x = clip48(n1x); o.p1y = clip48(n1y);
      o.v1x = clip48(w1x); o.v1y = clip48(w1y);
      o.p2x = clip48(n2x); o.p2y = clip48(n2y);
      o.v2x = clip48(w2x); o.v2y = clip48(w2y);
      return o;
   endfunction

   task automatic check_field(string name, logic [bpgc_pkg::DATA_W-1:0] want,
                              logic [bpgc_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type w;
      if (reset) begin
         grav_q = bpgc_pkg::GRAV_RESET;
         outcome_q.delete();
         mismatches = 0;
      end else begin
         if (csr.valid && csr.ready) grav_q = csr.data;
         if (req.valid && req.ready) outcome_q.push_back(predict_pair(grav_q));
         if (rsp.valid && rsp.ready) begin
            if (outcome_q.size() == 0) begin
               $error("rsp beat with no pair outstanding");
               mismatches++;
            end else begin
               w = outcome_q.pop_front();
               check_field("force_x", w.fx, rsp.force_x);
               check_field("force_y", w.fy, rsp.force_y);
               check_field("new_first_pos_x", w.p1x, rsp.new_first_pos_x);
               check_field("new_first_pos_y", w.p1y, rsp.new_first_pos_y);
               check_field("new_first_vel_x", w.v1x, rsp.new_first_vel_x);
               check_field("new_first_vel_y", w.v1y, rsp.new_first_vel_y);
               check_field("new_second_pos_x", w.p2x, rsp.new_second_pos_x);
               check_field("new_second_pos_y", w.p2y, rsp.new_second_pos_y);
               check_field("new_second_vel_x", w.v2x, rsp.new_second_vel_x);
               check_field("new_second_vel_y", w.v2y, rsp.new_second_vel_y);
               check_field("collided", bpgc_pkg::DATA_W'(w.hit),
                           bpgc_pkg::DATA_W'(rsp.collided));
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

>>> bench/body_pair_gravity_collision_tb.sv
// Top of the body_pair_gravity_collision bench: clock, reset, stimulus and verdict.
// Depends on bpgc_pkg, bpgc_if, the block itself and bpgc_scoreboard.
module body_pair_gravity_collision_tb;

   typedef logic [bpgc_pkg::DATA_W-1:0] coord_type;
   typedef logic [bpgc_pkg::MASS_W-1:0] mass_type;
   typedef logic [bpgc_pkg::RAD_W-1:0]  radius_type;

   logic clock;
   logic reset;
   logic quiet;
   int   mismatches, pending;

   bpgc_req_if req ();
   bpgc_rsp_if rsp ();
   bpgc_csr_if csr ();

   body_pair_gravity_collision dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr(csr));

   bpgc_scoreboard chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .mismatches(mismatches), .pending(pending));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic coord_type rnd48();
      return coord_type'({$urandom, $urandom});
   endfunction

   // signed value in [-2^(bits-1), 2^(bits-1))
   function automatic coord_type rnd_span(int bits);
      coord_type v;
      v = rnd48() & ((coord_type'(1) << bits) - 1);
      return v - (coord_type'(1) << (bits - 1));
   endfunction

   function automatic mass_type rnd_mass();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom_range(0, 1024);
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_pair(coord_type p1x, p1y, v1x, v1y, mass_type m1,
                            radius_type r1, coord_type p2x, p2y, v2x, v2y,
                            mass_type m2, radius_type r2);
      req.valid = 1'b1;
      req.first_pos_x = p1x;  req.first_pos_y = p1y;
      req.first_vel_x = v1x;  req.first_vel_y = v1y;
      req.first_mass = m1;    req.first_radius = r1;
      req.second_pos_x = p2x; req.second_pos_y = p2y;
      req.second_vel_x = v2x; req.second_vel_y = v2y;
      req.second_mass = m2;   req.second_radius = r2;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic send_random();
      coord_type p1x, p1y, v1x, v1y;
      radius_type r1, r2;
      p1x = rnd48(); p1y = rnd48(); v1x = rnd48(); v1y = rnd48();
      r1 = radius_type'(rnd48()); r2 = radius_type'(rnd48());
      case ($urandom_range(0, 9))
         0, 1: send_pair(p1x, p1y, v1x, v1y, rnd_mass(), r1,
                         rnd48(), rnd48(), rnd48(), rnd48(), rnd_mass(), r2);
         2, 3: begin
            // near pair, radii too small to touch most of the time
            p1x = rnd_span(40); p1y = rnd_span(40);
            send_pair(p1x, p1y, rnd_span(30), rnd_span(30), rnd_mass(),
                      radius_type'($urandom_range(0, 1 << 16)),
                      p1x + rnd_span(28), p1y + rnd_span(28),
                      rnd_span(30), rnd_span(30), rnd_mass(),
                      radius_type'($urandom_range(0, 1 << 16)));
         end
         default: begin
            // close pair that may overlap, with random content
            p1x = rnd_span(44); p1y = rnd_span(44);
            send_pair(p1x, p1y, rnd_span(34), rnd_span(34), rnd_mass(),
                      radius_type'(rnd48() & 48'h3F_FFFF), p1x + rnd_span(22),
                      p1y + rnd_span(22), rnd_span(34), rnd_span(34), rnd_mass(),
                      radius_type'(rnd48() & 48'h3F_FFFF));
         end
      endcase
   endtask

   task automatic write_grav(logic [bpgc_pkg::G_W-1:0] g);
      req.valid = 1'b0;
      wait (pending == 0);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.data = g;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic directed_pairs();
      coord_type one, maxp, minp;
      radius_type rone;
      one = 48'h1_0000;
      rone = 47'h1_0000;
      maxp = 48'h7FFF_FFFF_FFFF;
      minp = 48'h8000_0000_0000;
      // coincident bodies
      send_pair(5 * one, 5 * one, one, 0, 256, rone, 5 * one, 5 * one, -one, 0, 256, rone);
      // zero total mass while overlapping
      send_pair(0, 0, one, one, 0, 4 * rone, one, 0, 0, 0, 0, 4 * rone);
      // 3-4-5 triangle: radii sum equal to distance, then one above it
      send_pair(0, 0, one, 0, 512, 2 * rone, 3 * one, 4 * one, 0, one, 512, 3 * rone);
      send_pair(0, 0, one, 0, 512, 2 * rone, 3 * one, 4 * one, 0, one, 512, 3 * rone + 1);
      // overlapping and separating
      send_pair(0, 0, -one, 0, 256, rone, one, 0, one, 0, 768, rone);
      // extremes of positions, masses and radii
      send_pair(minp, minp, minp, maxp, 32'hFFFF_FFFF, {bpgc_pkg::RAD_W{1'b1}},
                maxp, maxp, maxp, minp, 32'hFFFF_FFFF, {bpgc_pkg::RAD_W{1'b1}});
      send_pair(maxp, 0, maxp, maxp, 32'hFFFF_FFFF, 0, maxp, 1, minp, minp, 32'hFFFF_FFFF, 0);
      send_pair(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0);
      send_pair(0, 0, maxp, minp, 32'hFFFF_FFFF, {bpgc_pkg::RAD_W{1'b1}}, 1, 1, minp, maxp,
                32'hFFFF_FFFF, 0);
      send_pair(-one, -one, 0, 0, 0, 0, one, one, 0, 0, 32'hFFFF_FFFF, 0);
   endtask

   initial begin
      logic [bpgc_pkg::G_W-1:0] grav_plan[5];
      quiet = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      csr.valid = 1'b0;
      csr.data = '0;
      req.first_pos_x = 0;  req.first_pos_y = 0;  req.first_vel_x = 0;  req.first_vel_y = 0;
      req.first_mass = 0;   req.first_radius = 0;
      req.second_pos_x = 0; req.second_pos_y = 0; req.second_vel_x = 0; req.second_vel_y = 0;
      req.second_mass = 0;  req.second_radius = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      grav_plan[0] = 32'hFFFF_FFFF;
      grav_plan[1] = 32'h0;
      grav_plan[2] = $urandom;
      grav_plan[3] = 32'h0000_0001;
      grav_plan[4] = bpgc_pkg::GRAV_RESET;

      directed_pairs();
      repeat (100) send_random();
      for (int ph = 0; ph < 5; ph++) begin
         write_grav(grav_plan[ph]);
         if (ph == 0) directed_pairs();
         if (ph == 4) quiet = 1'b1;
         repeat (100) send_random();
      end
      req.valid = 1'b0;

      wait (pending == 0);
      repeat (150) @(negedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // result side: ready in random bursts, always ready once quiet
   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp.ready = 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         if (!quiet) begin
            rsp.ready = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

endmodule
